// ----- rtl/piecewise_average_slope_fit_macros.svh -----
// Assertion macros used by the checker file of the slope fit block.
`ifndef PIECEWISE_AVERAGE_SLOPE_FIT_MACROS_SVH
`define PIECEWISE_AVERAGE_SLOPE_FIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PASF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slope fit check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PASF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slope fit check failed in the following cycle");

`endif

// ----- rtl/pasf_pkg.sv -----
// Package of widths and limits for the piecewise average slope fit block.
package pasf_pkg;

  localparam int unsigned CoordW   = 16;  // x and y sample width
  localparam int unsigned FracW    = 16;  // fraction bits of the Q32.16 results
  localparam int unsigned MeanW    = 48;  // width of the pair intercept and the means
  localparam int unsigned SumW     = 56;  // width of the running sums
  localparam int unsigned CntW     = 8;   // pair and segment counter width
  localparam int unsigned SlopeW   = 33;  // a pair slope always fits 33 signed bits
  localparam int unsigned ProdW    = CoordW + SlopeW;
  localparam int unsigned IcptW    = ProdW + 1;

  // Shared divider: numerator as wide as a sum, divisor as wide as a |dx|.
  localparam int unsigned DivW     = SumW;
  localparam int unsigned DivDenW  = CoordW;
  localparam int unsigned DivCntW  = $clog2(DivW);

  localparam logic [CntW-1:0] MaxPairs    = CntW'(255);
  localparam logic [CntW-1:0] MaxSegments = CntW'(255);

endpackage

// ----- rtl/piecewise_average_slope_fit.sv -----
// Piecewise average slope fit: mean of pairwise slopes and intercepts per segment.
//
// The block takes calibration points (x, y) one word at a time. Each point after the first of a
// fit pairs with the point before it; for every pair the block forms the slope dy/dx and the
// intercept y - x*slope in signed Q32.16 and adds both to running sums. A point flagged as
// closing a segment produces one result word carrying the mean slope, the mean intercept, the
// number of pairs averaged and a flag that is set when some pair had equal x values (such a
// pair is skipped). All divisions truncate toward zero. The arithmetic rests on one shared
// restoring divider that retires one quotient bit per cycle, plus one 16 x 33 bit multiplier.
// A point that forms a pair goes through the slope division, the multiply and the accumulation;
// a point that forms no pair and closes nothing only updates the fit state; a closing point
// then sets up the means, runs the two mean divisions when the segment holds pairs and publishes.
// The input side stalls while a point is being worked on. A finished result sits in an output
// register, so the next point is taken and processed while the previous result waits to be
// collected; only the hand-over of the next result waits for that register to empty.
module piecewise_average_slope_fit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pasf_pkg::CoordW-1:0]  x_value_i,
  input  logic signed [pasf_pkg::CoordW-1:0]  y_value_i,
  input  logic                                start_new_fit_i,
  input  logic                                closes_segment_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [pasf_pkg::CntW-1:0]    segment_index_o,
  output logic signed [pasf_pkg::MeanW-1:0]   mean_slope_o,
  output logic signed [pasf_pkg::MeanW-1:0]   mean_intercept_o,
  output logic        [pasf_pkg::CntW-1:0]    pairs_used_o,
  output logic                                zero_dx_seen_o
);
  import pasf_pkg::*;

  typedef enum logic [2:0] {
    StIdle,       // waiting for a point
    StSlopeDiv,   // dividing |dy| << 16 by |dx|
    StMul,        // x times slope
    StAcc,        // intercept and accumulation
    StMeanStart,  // set up the mean of the slopes
    StMeanSDiv,   // dividing the slope sum by the pair count
    StMeanIDiv,   // dividing the intercept sum by the pair count
    StPublish     // hand the result to the output register
  } state_e;

  state_e state_q;

  // Fit state.
  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic                     have_prev_q;
  logic signed [SumW-1:0]   slope_sum_q, icpt_sum_q;
  logic        [CntW-1:0]   pair_count_q, seg_q;
  logic                     dx_err_q;

  // Working registers for the point in flight.
  logic signed [CoordW-1:0] x_q, y_q;
  logic                     closes_q;
  logic                     neg_q;
  logic signed [SlopeW-1:0] slope_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [MeanW-1:0]  mean_s_q, mean_i_q;

  // Shared divider.
  logic [DivW-1:0]    div_quo_q, div_quo_d;
  logic [DivDenW-1:0] div_rem_q, div_rem_d, div_den_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_last;

  // Output register.
  logic                     out_valid_q;
  logic [CntW-1:0]          seg_out_q, pairs_out_q;
  logic signed [MeanW-1:0]  ms_out_q, mi_out_q;
  logic                     dx_out_q;

  // Point decode at acceptance.
  logic                     accept;
  logic                     have_eff;
  logic signed [CoordW:0]   dx, dy;
  logic        [CoordW-1:0] dx_mag, dy_mag;
  logic                     pair_ok;

  // Intercept and sum magnitudes.
  logic signed [IcptW-1:0]  icpt_full;
  logic signed [MeanW-1:0]  icpt_sat;
  logic        [SumW-1:0]   slope_sum_mag, icpt_sum_mag;
  logic        [SlopeW-1:0] slope_mag;
  logic        [MeanW-1:0]  mean_mag;
  logic                     out_free;
  logic                     publish;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign publish    = (state_q == StPublish) && out_free;

  // A start flag forgets the previous point before this one is looked at.
  assign have_eff = have_prev_q && !start_new_fit_i;
  assign dx       = (CoordW+1)'(x_value_i) - (CoordW+1)'(prev_x_q);
  assign dy       = (CoordW+1)'(y_value_i) - (CoordW+1)'(prev_y_q);
  assign dx_mag   = dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
  assign dy_mag   = dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
  assign pair_ok  = have_eff && (dx != '0) && (pair_count_q < MaxPairs);

  // One restoring step: shift in the next numerator bit, subtract when it fits.
  always_comb begin
    logic [DivDenW:0] rem_sh;
    logic             fits;
    rem_sh    = {div_rem_q, div_quo_q[DivW-1]};
    fits      = (rem_sh >= {1'b0, div_den_q});
    div_rem_d = fits ? DivDenW'(rem_sh - {1'b0, div_den_q}) : DivDenW'(rem_sh);
    div_quo_d = {div_quo_q[DivW-2:0], fits};
  end
  assign div_last = (div_cnt_q == DivCntW'(DivW - 1));

  // Intercept in Q.16; clamped to the 48-bit range.
  assign icpt_full = (IcptW'(y_q) <<< FracW) - IcptW'(prod_q);
  always_comb begin
    if (icpt_full[IcptW-1:MeanW-1] == '0 || icpt_full[IcptW-1:MeanW-1] == '1) begin
      icpt_sat = MeanW'(icpt_full);
    end else if (icpt_full[IcptW-1]) begin
      icpt_sat = {1'b1, {(MeanW-1){1'b0}}};
    end else begin
      icpt_sat = {1'b0, {(MeanW-1){1'b1}}};
    end
  end

  assign slope_sum_mag = slope_sum_q[SumW-1] ? SumW'(-slope_sum_q) : SumW'(slope_sum_q);
  assign icpt_sum_mag  = icpt_sum_q[SumW-1]  ? SumW'(-icpt_sum_q)  : SumW'(icpt_sum_q);
  assign slope_mag     = {1'b0, div_quo_d[SlopeW-2:0]};
  assign mean_mag      = div_quo_d[MeanW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_prev_q  <= 1'b0;
      slope_sum_q  <= '0;
      icpt_sum_q   <= '0;
      pair_count_q <= '0;
      seg_q        <= '0;
      dx_err_q     <= 1'b0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // A new result word may replace one that is being collected in the same cycle.
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            x_q         <= x_value_i;
            y_q         <= y_value_i;
            closes_q    <= closes_segment_i;
            prev_x_q    <= x_value_i;
            prev_y_q    <= y_value_i;
            have_prev_q <= 1'b1;
            if (start_new_fit_i) begin
              seg_q        <= '0;
              slope_sum_q  <= '0;
              icpt_sum_q   <= '0;
              pair_count_q <= '0;
              dx_err_q     <= 1'b0;
            end
            if (have_eff && dx == '0) begin
              dx_err_q <= 1'b1;
            end
            if (pair_ok) begin
              neg_q     <= dx[CoordW] ^ dy[CoordW];
              div_quo_q <= DivW'({dy_mag, {FracW{1'b0}}});
              div_rem_q <= '0;
              div_den_q <= dx_mag;
              div_cnt_q <= '0;
              state_q   <= StSlopeDiv;
            end else if (closes_segment_i) begin
              state_q <= StMeanStart;
            end
          end
        end
        StSlopeDiv: begin
          div_quo_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            slope_q <= neg_q ? -$signed(slope_mag) : $signed(slope_mag);
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= ProdW'(x_q) * ProdW'(slope_q);
          state_q <= StAcc;
        end
        StAcc: begin
          // 255 values of at most 2^47 fit the 56-bit sums without clamping.
          slope_sum_q  <= slope_sum_q + SumW'(slope_q);
          icpt_sum_q   <= icpt_sum_q + SumW'(icpt_sat);
          pair_count_q <= pair_count_q + 1'b1;
          state_q      <= closes_q ? StMeanStart : StIdle;
        end
        StMeanStart: begin
          if (pair_count_q == '0) begin
            mean_s_q <= '0;
            mean_i_q <= '0;
            state_q  <= StPublish;
          end else begin
            neg_q     <= slope_sum_q[SumW-1];
            div_quo_q <= slope_sum_mag;
            div_rem_q <= '0;
            div_den_q <= DivDenW'(pair_count_q);
            div_cnt_q <= '0;
            state_q   <= StMeanSDiv;
          end
        end
        StMeanSDiv: begin
          if (div_last) begin
            // A mean of in-range values stays in range; the low 48 bits are exact.
            mean_s_q  <= neg_q ? -$signed(mean_mag) : $signed(mean_mag);
            neg_q     <= icpt_sum_q[SumW-1];
            div_quo_q <= icpt_sum_mag;
            div_rem_q <= '0;
            div_cnt_q <= '0;
            state_q   <= StMeanIDiv;
          end else begin
            div_quo_q <= div_quo_d;
            div_rem_q <= div_rem_d;
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        StMeanIDiv: begin
          div_quo_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            mean_i_q <= neg_q ? -$signed(mean_mag) : $signed(mean_mag);
            state_q  <= StPublish;
          end
        end
        StPublish: begin
          if (out_free) begin
            seg_out_q    <= seg_q;
            ms_out_q     <= mean_s_q;
            mi_out_q     <= mean_i_q;
            pairs_out_q  <= pair_count_q;
            dx_out_q     <= dx_err_q;
            slope_sum_q  <= '0;
            icpt_sum_q   <= '0;
            pair_count_q <= '0;
            dx_err_q     <= 1'b0;
            if (seg_q < MaxSegments - 1'b1) begin
              seg_q <= seg_q + 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_index_o  = seg_out_q;
  assign mean_slope_o     = ms_out_q;
  assign mean_intercept_o = mi_out_q;
  assign pairs_used_o     = pairs_out_q;
  assign zero_dx_seen_o   = dx_out_q;

endmodule

// ----- rtl/pasf_checker.sv -----
// Port-level checker for the piecewise average slope fit block, with its bind.
`include "piecewise_average_slope_fit_macros.svh"

module pasf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               closes_segment_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic        [pasf_pkg::CntW-1:0]   segment_index_o,
  input logic signed [pasf_pkg::MeanW-1:0]  mean_slope_o,
  input logic signed [pasf_pkg::MeanW-1:0]  mean_intercept_o,
  input logic        [pasf_pkg::CntW-1:0]   pairs_used_o,
  input logic                               zero_dx_seen_o
);
  import pasf_pkg::*;

  logic                        out_held;
  logic [2*CntW+2*MeanW:0]     out_word;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {segment_index_o, mean_slope_o, mean_intercept_o, pairs_used_o,
                     zero_dx_seen_o};

  // A stalled result word stays offered and unchanged.
  `PASF_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_held, out_valid_o)
  `PASF_ASSERT_NEXT(a_out_word_holds, clk_i, rst_ni, out_held, $stable(out_word))

  // A closing point always keeps the block busy while the means are formed.
  `PASF_ASSERT_NEXT(a_close_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && closes_segment_i, in_stall_o)

  // A segment without pairs reports zero means.
  `PASF_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_o && pairs_used_o == '0, mean_slope_o == '0 && mean_intercept_o == '0)

  // A new result only appears after the block has been working on a point.
  `PASF_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind piecewise_average_slope_fit pasf_checker u_pasf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .closes_segment_i (closes_segment_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .segment_index_o  (segment_index_o),
  .mean_slope_o     (mean_slope_o),
  .mean_intercept_o (mean_intercept_o),
  .pairs_used_o     (pairs_used_o),
  .zero_dx_seen_o   (zero_dx_seen_o)
);

// ----- dv/tb_piecewise_average_slope_fit.sv -----
// Self-checking testbench for the piecewise average slope fit block.
`timescale 1ns / 100ps

module tb_piecewise_average_slope_fit;

  // A coordinate as the block sees it, and one input word and one result word as the
  // testbench keeps them.
  typedef logic signed [pasf_pkg::CoordW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   start;
    logic   closes;
  } point_t;

  typedef struct {
    logic        [pasf_pkg::CntW-1:0]  segment_index;
    logic signed [pasf_pkg::MeanW-1:0] mean_slope;
    logic signed [pasf_pkg::MeanW-1:0] mean_intercept;
    logic        [pasf_pkg::CntW-1:0]  pairs_used;
    logic                              zero_dx_seen;
  } segment_mean_t;

  // Saturation bounds of the Q32.16 pair values and means, and of the 56-bit sums.
  localparam longint MeanMax = (longint'(1) <<< (pasf_pkg::MeanW - 1)) - 1;
  localparam longint MeanMin = -MeanMax - 1;
  localparam longint SumMax  = (longint'(1) <<< (pasf_pkg::SumW - 1)) - 1;
  localparam longint SumMin  = -SumMax - 1;
  localparam longint OneQ    = longint'(1) <<< pasf_pkg::FracW;

  // A closing point with pairs keeps the block busy for less than this settle time, so this
  // many quiet cycles at the end is enough for any stray word to show itself.
  localparam int unsigned SettleCycles = 200;

  logic                               clk_i            = 1'b0;
  logic                               rst_ni           = 1'b0;
  logic                               in_valid_i       = 1'b0;
  logic                               in_stall_o;
  coord_t                             x_value_i        = '0;
  coord_t                             y_value_i        = '0;
  logic                               start_new_fit_i  = 1'b0;
  logic                               closes_segment_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i      = 1'b0;
  logic        [pasf_pkg::CntW-1:0]   segment_index_o;
  logic signed [pasf_pkg::MeanW-1:0]  mean_slope_o;
  logic signed [pasf_pkg::MeanW-1:0]  mean_intercept_o;
  logic        [pasf_pkg::CntW-1:0]   pairs_used_o;
  logic                               zero_dx_seen_o;

  piecewise_average_slope_fit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .x_value_i        (x_value_i),
    .y_value_i        (y_value_i),
    .start_new_fit_i  (start_new_fit_i),
    .closes_segment_i (closes_segment_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .segment_index_o  (segment_index_o),
    .mean_slope_o     (mean_slope_o),
    .mean_intercept_o (mean_intercept_o),
    .pairs_used_o     (pairs_used_o),
    .zero_dx_seen_o   (zero_dx_seen_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Our own copy of the fit state: the previous point, the running sums of the open segment
  // and the segment number.
  coord_t      last_x;
  coord_t      last_y;
  bit          have_last;
  longint      slope_acc;
  longint      icpt_acc;
  int          pairs_acc;
  int          seg_no;
  bit          dx_zero_flag;

  // Segment means that have been worked out but not yet seen on the result side, oldest first.
  segment_mean_t pending_segment_means[$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_segment_sums();
    slope_acc    = 0;
    icpt_acc     = 0;
    pairs_acc    = 0;
    dx_zero_flag = 1'b0;
  endfunction

  // Folds one accepted point into the running sums. A closing point queues the means of its
  // segment. SystemVerilog division of signed operands truncates toward zero, which is just
  // the rounding that the block uses for the pair slope and both means.
  function automatic void fold_point(input point_t p);
    longint        dx;
    longint        dy;
    longint        slope;
    longint        icpt;
    longint        ms;
    longint        mi;
    segment_mean_t r;
    if (p.start) begin
      have_last = 1'b0;
      seg_no    = 0;
      clear_segment_sums();
    end
    if (have_last) begin
      dx = longint'(p.x) - longint'(last_x);
      dy = longint'(p.y) - longint'(last_y);
      if (dx == 0) begin
        // A vertical pair has no slope: it is skipped and only raises the flag.
        dx_zero_flag = 1'b1;
      end else if (pairs_acc < int'(pasf_pkg::MaxPairs)) begin
        slope     = clip((dy * OneQ) / dx, MeanMin, MeanMax);
        icpt      = clip(longint'(p.y) * OneQ - longint'(p.x) * slope, MeanMin, MeanMax);
        slope_acc = clip(slope_acc + slope, SumMin, SumMax);
        icpt_acc  = clip(icpt_acc + icpt, SumMin, SumMax);
        pairs_acc++;
      end
    end
    // The closing point stays as the previous point, so the pair that straddles a boundary
    // belongs to the following segment.
    last_x    = p.x;
    last_y    = p.y;
    have_last = 1'b1;
    if (p.closes) begin
      r.segment_index  = seg_no[pasf_pkg::CntW-1:0];
      r.mean_slope     = '0;
      r.mean_intercept = '0;
      if (pairs_acc != 0) begin
        ms               = clip(slope_acc / longint'(pairs_acc), MeanMin, MeanMax);
        mi               = clip(icpt_acc / longint'(pairs_acc), MeanMin, MeanMax);
        r.mean_slope     = ms[pasf_pkg::MeanW-1:0];
        r.mean_intercept = mi[pasf_pkg::MeanW-1:0];
      end
      r.pairs_used   = pairs_acc[pasf_pkg::CntW-1:0];
      r.zero_dx_seen = dx_zero_flag;
      pending_segment_means.push_back(r);
      clear_segment_sums();
      if (seg_no < int'(pasf_pkg::MaxSegments) - 1) begin
        seg_no++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Every result word taken by the testbench is held against the oldest pending expectation,
  // field by field.
  always @(posedge clk_i) begin : check_results
    segment_mean_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_segment_means.size() == 0) begin
        report_mismatch("unexpected result word, segment_index", 64'(segment_index_o), 64'd0);
      end else begin
        want = pending_segment_means.pop_front();
        if (segment_index_o !== want.segment_index)
          report_mismatch("segment_index", 64'(segment_index_o), 64'(want.segment_index));
        if (mean_slope_o !== want.mean_slope)
          report_mismatch("mean_slope", 64'(mean_slope_o), 64'(want.mean_slope));
        if (mean_intercept_o !== want.mean_intercept)
          report_mismatch("mean_intercept", 64'(mean_intercept_o), 64'(want.mean_intercept));
        if (pairs_used_o !== want.pairs_used)
          report_mismatch("pairs_used", 64'(pairs_used_o), 64'(want.pairs_used));
        if (zero_dx_seen_o !== want.zero_dx_seen)
          report_mismatch("zero_dx_seen", 64'(zero_dx_seen_o), 64'(want.zero_dx_seen));
      end
    end
  end

  // The result side runs through stretches of its own: open, held for a few cycles or for a
  // long while, and flickering at random from cycle to cycle.
  int unsigned rx_mode  = 0;
  int unsigned rx_left  = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 5);
      case (rx_mode) inside
        [0:1]:   rx_left = $urandom_range(1, 150);
        2:       rx_left = $urandom_range(1, 8);
        3:       rx_left = $urandom_range(30, 200);
        default: rx_left = $urandom_range(10, 60);
      endcase
    end else begin
      rx_left--;
    end
    case (rx_mode) inside
      [0:1]:   out_stall_i <= 1'b0;
      [2:3]:   out_stall_i <= 1'b1;
      default: out_stall_i <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9)) inside
      [0:2]:   return 0;
      8:       return $urandom_range(9, 70);
      9:       return $urandom_range(100, 200);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Sends one point and returns at the edge that accepts it. Words go out in bursts; between
  // bursts valid may drop for a random gap. The caller is always at a rising edge, and after an
  // accepted word valid stays high only if another word follows in the same step, so nothing
  // is ever taken twice.
  task automatic send_point(input point_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    x_value_i        <= p.x;
    y_value_i        <= p.y;
    start_new_fit_i  <= p.start;
    closes_segment_i <= p.closes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_point(p);
  endtask

  // Holds the input side quiet until every queued segment mean has been collected.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_segment_means.size() != 0);
  endtask

  function automatic point_t mk_point(input int x, input int y, input bit start,
                                      input bit closes);
    point_t p;
    p.x      = coord_t'(x);
    p.y      = coord_t'(y);
    p.start  = start;
    p.closes = closes;
    return p;
  endfunction

  // Random coordinate: mostly full range, sometimes the extremes, sometimes close to the
  // previous value so that equal x values and small steps turn up often.
  function automatic coord_t pick_coord(input coord_t near);
    case ($urandom_range(0, 3))
      0:       return near + coord_t'($urandom_range(0, 6)) - coord_t'(3);
      1:       return $urandom_range(0, 1) ? coord_t'(16'h7fff) : coord_t'(16'h8000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // The steepest slope, reached with dx and dy both negative and both positive, the widest x span,
  // and slopes that do not divide evenly so that truncation toward zero shows in both directions.
  task automatic test_extreme_pairs();
    send_point(mk_point(-32768, -32768, 1, 0));
    send_point(mk_point(32767, 32767, 0, 0));
    send_point(mk_point(32766, -32768, 0, 0));
    send_point(mk_point(32767, 32767, 0, 1));
    send_point(mk_point(0, 0, 1, 0));
    send_point(mk_point(3, 1, 0, 0));
    send_point(mk_point(6, 0, 0, 1));
  endtask

  // A pair with equal x is skipped but flagged; a segment made only of such pairs reports
  // zero means, zero pairs and the flag.
  task automatic test_equal_x();
    send_point(mk_point(5, 10, 1, 0));
    send_point(mk_point(5, -7, 0, 0));
    send_point(mk_point(8, 20, 0, 1));
    send_point(mk_point(8, 3, 0, 0));
    send_point(mk_point(8, -32768, 0, 1));
  endtask

  // The first point of a fit closing at once gives an empty segment; the point after a close
  // pairs across the boundary into the next segment.
  task automatic test_empty_segments();
    send_point(mk_point(1, 2, 1, 1));
    send_point(mk_point(-32768, 0, 0, 1));
    send_point(mk_point(7, 7, 1, 1));
  endtask

  // A new fit in the middle of an open segment drops its sums and restarts the numbering.
  task automatic test_restart_mid_segment();
    send_point(mk_point(10, 10, 1, 0));
    send_point(mk_point(20, 30, 0, 0));
    send_point(mk_point(30, -40, 0, 0));
    send_point(mk_point(100, 100, 1, 0));
    send_point(mk_point(-100, 50, 0, 1));
  endtask

  // One segment with far more pairs than the counter holds: x climbs strictly so that every
  // pair counts until the cap is reached.
  task automatic test_pair_cap();
    point_t p;
    int     k;
    for (k = 0; k < 300; k++) begin
      p = mk_point(-30000 + 200 * k + int'($urandom_range(0, 150)), 0, k == 0, k == 299);
      p.y = coord_t'($urandom);
      send_point(p);
    end
  endtask

  // Every point closes a segment, so the segment number runs up to its limit and stays there.
  task automatic test_segment_cap();
    point_t p;
    int     k;
    for (k = 0; k < 260; k++) begin
      p.x      = pick_coord(last_x);
      p.y      = pick_coord(last_y);
      p.start  = (k == 0);
      p.closes = 1'b1;
      send_point(p);
    end
  endtask

  // Well-formed fits of a few segments with random content. Now and then a word carries
  // random flags instead, which breaks a segment off or restarts the fit part way through.
  task automatic test_random_fits(input int unsigned n_points);
    point_t      p;
    int unsigned sent;
    int unsigned seg_len;
    int unsigned k;
    bit          first;
    sent = 0;
    while (sent < n_points) begin
      first = 1'b1;
      repeat ($urandom_range(1, 6)) begin
        seg_len = $urandom_range(1, 12);
        for (k = 0; k < seg_len; k++) begin
          p.x      = pick_coord(last_x);
          p.y      = pick_coord(last_y);
          p.start  = first && ($urandom_range(0, 3) != 0);
          p.closes = (k == seg_len - 1);
          if ($urandom_range(0, 15) == 0) begin
            p.start  = 1'($urandom_range(0, 1));
            p.closes = 1'($urandom_range(0, 1));
          end
          first = 1'b0;
          send_point(p);
          sent++;
        end
      end
    end
  endtask

  initial begin
    have_last = 1'b0;
    last_x    = '0;
    last_y    = '0;
    seg_no    = 0;
    clear_segment_sums();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_pairs();
    test_equal_x();
    test_empty_segments();
    test_restart_mid_segment();
    test_pair_cap();
    // Let everything come out before the long run of closing points begins.
    drain_results();
    test_segment_cap();
    test_random_fits(250);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run, with every word held up by the longest gaps and stalls.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
